[src/dtq_pkg.sv]
`default_nettype none

package dtq_pkg;

    localparam int KIND_W          = 2;
    localparam int DELAY_W         = 32;
    localparam int SLOT_ID_W       = 4;
    localparam int RKIND_W         = 3;
    localparam int WAIT_W          = 32;
    localparam int DEF_TIMER_SLOTS = 16;
    localparam int DEF_CLOCK_BITS  = 48;

    localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

    localparam logic [RKIND_W-1:0] RES_ADDED   = 3'd0;
    localparam logic [RKIND_W-1:0] RES_FULL    = 3'd1;
    localparam logic [RKIND_W-1:0] RES_DELETED = 3'd2;
    localparam logic [RKIND_W-1:0] RES_IGNORED = 3'd3;
    localparam logic [RKIND_W-1:0] RES_EXPIRED = 3'd4;
    localparam logic [RKIND_W-1:0] RES_QUIET   = 3'd5;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic borrow;
        logic zero;
    } t_alu_flags;

endpackage

`default_nettype wire

[src/dtq_in_if.sv]
`default_nettype none

interface dtq_in_if import dtq_pkg::*;;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [DELAY_W-1:0]   delay_ms;
    logic [SLOT_ID_W-1:0] slot_id;

    modport source (output valid, output kind, output delay_ms, output slot_id, input ready);
    modport sink   (input valid, input kind, input delay_ms, input slot_id, output ready);

endinterface

`default_nettype wire

[src/dtq_res_if.sv]
`default_nettype none

interface dtq_res_if import dtq_pkg::*;;

    logic                 valid;
    logic                 ready;
    logic [RKIND_W-1:0]   result_kind;
    logic [SLOT_ID_W-1:0] slot_out;
    logic [WAIT_W-1:0]    wait_ms;
    logic                 queue_empty;
    logic                 last;

    modport source (
        output valid, output result_kind, output slot_out, output wait_ms,
        output queue_empty, output last, input ready
    );
    modport sink (
        input valid, input result_kind, input slot_out, input wait_ms,
        input queue_empty, input last, output ready
    );

endinterface

`default_nettype wire

[src/deadline_timer_queue.sv]
`default_nettype none

// One-shot timer queue with a millisecond clock that advances by one on each tick item.
// Pending timers sit in an order memory with one read and one write port, sorted by
// deadline, earliest first, and all deadline arithmetic goes through one shared
// CLOCK_BITS-wide add/subtract unit. An add first sums its deadline, then moves one memory
// entry per cycle while the new timer sinks into place; a delete searches, then closes the
// gap one entry per cycle; a refused add or an ignored delete goes straight to its result;
// a tick advances the clock and checks the head, then gives one result per timer that it
// expires, or a quiet result when none is due. A result that waits on a stalled output
// holds the sequencer until the output register is free. The input is taken only while
// the sequencer is idle; the last result can still wait in the output register while the
// next item is taken. Every result carries the wait until the earliest pending deadline,
// clamped to 32 bits, or the empty flag.
module deadline_timer_queue import dtq_pkg::*; #(
    parameter int TIMER_SLOTS = DEF_TIMER_SLOTS,
    parameter int CLOCK_BITS  = DEF_CLOCK_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dtq_in_if.sink     i_item,
    dtq_res_if.source  o_res
);

    localparam int SLOT_W = $clog2(TIMER_SLOTS);
    localparam int CNT_W  = SLOT_W + 1;

    typedef struct packed {
        logic [CLOCK_BITS-1:0] dl;
        logic [SLOT_W-1:0]     slot;
    } t_entry;

    typedef enum logic [8:0] {
        ST_IDLE       = 9'b000000001,
        ST_ADD_SUM    = 9'b000000010,
        ST_ADD_SCAN   = 9'b000000100,
        ST_ADD_PUT    = 9'b000001000,
        ST_DEL_FIND   = 9'b000010000,
        ST_REM        = 9'b000100000,
        ST_TICK_INC   = 9'b001000000,
        ST_TICK_CHECK = 9'b010000000,
        ST_EMIT       = 9'b100000000
    } t_state;

    t_state                 r_state, n_state;
    logic [CLOCK_BITS-1:0]  r_now, n_now;
    logic [TIMER_SLOTS-1:0] r_in_use, n_in_use;
    logic [CNT_W-1:0]       r_count, n_count;
    t_entry                 r_head, n_head;
    logic [SLOT_W-1:0]      r_idx, n_idx;
    logic [CLOCK_BITS-1:0]  r_new_dl, n_new_dl;
    logic [SLOT_W-1:0]      r_new_slot, n_new_slot;
    logic [SLOT_W-1:0]      r_del_slot, n_del_slot;
    logic [DELAY_W-1:0]     r_delay, n_delay;
    logic [RKIND_W-1:0]     r_res_kind, n_res_kind;
    logic [SLOT_ID_W-1:0]   r_res_slot, n_res_slot;

    logic                   r_out_valid, n_out_valid;
    logic [RKIND_W-1:0]     r_out_kind, n_out_kind;
    logic [SLOT_ID_W-1:0]   r_out_slot, n_out_slot;
    logic [WAIT_W-1:0]      r_out_wait, n_out_wait;
    logic                   r_out_empty, n_out_empty;
    logic                   r_out_last, n_out_last;

    t_entry                 ord_mem [TIMER_SLOTS];
    t_entry                 r_rd;
    logic                   mem_we;
    logic [SLOT_W-1:0]      mem_waddr;
    t_entry                 mem_wdata;
    logic [SLOT_W-1:0]      mem_raddr;

    logic [CLOCK_BITS-1:0]  alu_a, alu_b, alu_sum;
    t_alu_op                alu_op;
    t_alu_flags             alu_flags;

    logic                   pick_found;
    logic [SLOT_W-1:0]      pick_slot;
    logic [SLOT_W-1:0]      del_slot;
    logic                   del_ok;
    logic                   head_due;
    logic                   emit_last;
    logic                   out_free;
    logic [WAIT_W-1:0]      wait_val;
    t_entry                 new_entry;

    dtq_alu #(
        .CLOCK_BITS (CLOCK_BITS)
    ) u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_op    (alu_op),
        .o_sum   (alu_sum),
        .o_flags (alu_flags)
    );

    dtq_free_pick #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_free_pick (
        .i_in_use (r_in_use),
        .o_found  (pick_found),
        .o_slot   (pick_slot)
    );

    always_comb begin
        alu_a  = r_head.dl;
        alu_b  = r_now;
        alu_op = ALU_SUB;
        case (r_state)
            ST_ADD_SUM: begin
                alu_a  = r_now;
                alu_b  = CLOCK_BITS'(r_delay);
                alu_op = ALU_ADD;
            end
            ST_TICK_INC: begin
                alu_a  = r_now;
                alu_b  = CLOCK_BITS'(1);
                alu_op = ALU_ADD;
            end
            ST_ADD_SCAN: begin
                alu_a  = r_rd.dl;
                alu_b  = r_new_dl;
                alu_op = ALU_SUB;
            end
            default: begin
                alu_a  = r_head.dl;
                alu_b  = r_now;
                alu_op = ALU_SUB;
            end
        endcase
    end

    assign del_slot  = SLOT_W'(i_item.slot_id);
    assign del_ok    = (32'(i_item.slot_id) < 32'(TIMER_SLOTS)) && r_in_use[del_slot];
    assign head_due  = (r_count != '0) && (alu_flags.borrow || alu_flags.zero);
    assign emit_last = (r_res_kind != RES_EXPIRED) || !head_due;
    assign out_free  = !r_out_valid || o_res.ready;
    assign new_entry = '{dl: r_new_dl, slot: r_new_slot};

    always_comb begin
        if (alu_flags.borrow || alu_flags.zero) begin
            wait_val = '0;
        end else if (|alu_sum[CLOCK_BITS-1:WAIT_W]) begin
            wait_val = '1;
        end else begin
            wait_val = alu_sum[WAIT_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_in_use    = r_in_use;
        n_count     = r_count;
        n_head      = r_head;
        n_idx       = r_idx;
        n_new_dl    = r_new_dl;
        n_new_slot  = r_new_slot;
        n_del_slot  = r_del_slot;
        n_delay     = r_delay;
        n_res_kind  = r_res_kind;
        n_res_slot  = r_res_slot;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_slot  = r_out_slot;
        n_out_wait  = r_out_wait;
        n_out_empty = r_out_empty;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = r_rd;
        mem_raddr   = r_idx;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    case (i_item.kind)
                        KIND_ADD: begin
                            n_delay = i_item.delay_ms;
                            if (pick_found) begin
                                n_new_slot = pick_slot;
                                n_res_kind = RES_ADDED;
                                n_res_slot = SLOT_ID_W'(pick_slot);
                                n_state    = ST_ADD_SUM;
                            end else begin
                                n_res_kind = RES_FULL;
                                n_res_slot = '0;
                                n_state    = ST_EMIT;
                            end
                        end
                        KIND_DEL: begin
                            n_res_slot = i_item.slot_id;
                            if (del_ok) begin
                                n_in_use[del_slot] = 1'b0;
                                n_del_slot = del_slot;
                                n_res_kind = RES_DELETED;
                                n_idx      = '0;
                                mem_raddr  = '0;
                                n_state    = ST_DEL_FIND;
                            end else begin
                                n_res_kind = RES_IGNORED;
                                n_state    = ST_EMIT;
                            end
                        end
                        KIND_TICK: begin
                            n_state = ST_TICK_INC;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADD_SUM: begin
                n_new_dl = alu_sum;
                if (r_count == '0) begin
                    n_idx   = '0;
                    n_state = ST_ADD_PUT;
                end else begin
                    n_idx     = SLOT_W'(r_count);
                    mem_raddr = SLOT_W'(r_count - CNT_W'(1));
                    n_state   = ST_ADD_SCAN;
                end
            end
            ST_ADD_SCAN: begin
                if (!alu_flags.borrow) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = r_rd;
                    if (r_idx == SLOT_W'(1)) begin
                        n_idx   = '0;
                        n_state = ST_ADD_PUT;
                    end else begin
                        n_idx     = r_idx - SLOT_W'(1);
                        mem_raddr = r_idx - SLOT_W'(2);
                    end
                end else begin
                    n_state = ST_ADD_PUT;
                end
            end
            ST_ADD_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = new_entry;
                if (r_idx == '0) begin
                    n_head = new_entry;
                end
                n_count              = r_count + CNT_W'(1);
                n_in_use[r_new_slot] = 1'b1;
                n_state              = ST_EMIT;
            end
            ST_DEL_FIND: begin
                mem_raddr = r_idx + SLOT_W'(1);
                if (r_rd.slot == r_del_slot) begin
                    if ((CNT_W'(r_idx) + CNT_W'(1)) < r_count) begin
                        n_state = ST_REM;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                        n_state = ST_EMIT;
                    end
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            ST_REM: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_rd;
                if (r_idx == '0) begin
                    n_head = r_rd;
                end
                if ((CNT_W'(r_idx) + CNT_W'(2)) < r_count) begin
                    mem_raddr = r_idx + SLOT_W'(2);
                    n_idx     = r_idx + SLOT_W'(1);
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = ST_EMIT;
                end
            end
            ST_TICK_INC: begin
                n_now   = alu_sum;
                n_state = ST_TICK_CHECK;
            end
            ST_TICK_CHECK: begin
                if (head_due) begin
                    n_res_kind             = RES_EXPIRED;
                    n_res_slot             = SLOT_ID_W'(r_head.slot);
                    n_in_use[r_head.slot]  = 1'b0;
                    n_idx                  = '0;
                    mem_raddr              = SLOT_W'(1);
                    if (r_count > CNT_W'(1)) begin
                        n_state = ST_REM;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                        n_state = ST_EMIT;
                    end
                end else begin
                    n_res_kind = RES_QUIET;
                    n_res_slot = '0;
                    n_state    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    n_out_slot  = r_res_slot;
                    n_out_empty = (r_count == '0);
                    n_out_wait  = (r_count == '0) ? '0 : wait_val;
                    n_out_last  = emit_last;
                    n_state     = emit_last ? ST_IDLE : ST_TICK_CHECK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_now       <= '0;
            r_in_use    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_in_use    <= n_in_use;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head      <= n_head;
        r_idx       <= n_idx;
        r_new_dl    <= n_new_dl;
        r_new_slot  <= n_new_slot;
        r_del_slot  <= n_del_slot;
        r_delay     <= n_delay;
        r_res_kind  <= n_res_kind;
        r_res_slot  <= n_res_slot;
        r_out_kind  <= n_out_kind;
        r_out_slot  <= n_out_slot;
        r_out_wait  <= n_out_wait;
        r_out_empty <= n_out_empty;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            ord_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= ord_mem[mem_raddr];
    end

    assign i_item.ready      = (r_state == ST_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.result_kind = r_out_kind;
    assign o_res.slot_out    = r_out_slot;
    assign o_res.wait_ms     = r_out_wait;
    assign o_res.queue_empty = r_out_empty;
    assign o_res.last        = r_out_last;

endmodule

`default_nettype wire

[src/dtq_alu.sv]
`default_nettype none

module dtq_alu import dtq_pkg::*; #(
    parameter int CLOCK_BITS = DEF_CLOCK_BITS
) (
    input  wire logic [CLOCK_BITS-1:0] i_a,
    input  wire logic [CLOCK_BITS-1:0] i_b,
    input  wire t_alu_op               i_op,
    output      logic [CLOCK_BITS-1:0] o_sum,
    output      t_alu_flags            o_flags
);

    localparam int SUM_W = CLOCK_BITS + 1;

    logic [CLOCK_BITS-1:0] b_eff;
    logic [SUM_W-1:0]      full;

    assign b_eff = (i_op == ALU_SUB) ? ~i_b : i_b;
    assign full  = {1'b0, i_a} + {1'b0, b_eff} + SUM_W'(i_op == ALU_SUB);
    assign o_sum = full[CLOCK_BITS-1:0];

    assign o_flags.borrow = (i_op == ALU_SUB) && !full[CLOCK_BITS];
    assign o_flags.zero   = (full[CLOCK_BITS-1:0] == '0);

endmodule

`default_nettype wire

[src/dtq_free_pick.sv]
`default_nettype none

module dtq_free_pick import dtq_pkg::*; #(
    parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
    input  wire logic [TIMER_SLOTS-1:0]         i_in_use,
    output      logic                           o_found,
    output      logic [$clog2(TIMER_SLOTS)-1:0] o_slot
);

    localparam int SLOT_W = $clog2(TIMER_SLOTS);

    always_comb begin
        o_found = 1'b0;
        o_slot  = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!i_in_use[i]) begin
                o_found = 1'b1;
                o_slot  = SLOT_W'(i);
            end
        end
    end

endmodule

`default_nettype wire
